[hw/rtl/jfs_pkg.sv]
`default_nettype none
package jfs_pkg;

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkSof0   = 8'hC0;
  localparam logic [7:0] MarkSof2   = 8'hC2;

  localparam int QueueDepth = 3;

  typedef enum logic [3:0] {
    PH_SOI_A  = 4'd0,
    PH_SOI_B  = 4'd1,
    PH_MARK_A = 4'd2,
    PH_MARK_B = 4'd3,
    PH_SOF_L1 = 4'd4,
    PH_SOF_L2 = 4'd5,
    PH_SOF_P  = 4'd6,
    PH_H_HI   = 4'd7,
    PH_H_LO   = 4'd8,
    PH_W_HI   = 4'd9,
    PH_W_LO   = 4'd10,
    PH_SEG_HI = 4'd11,
    PH_SEG_LO = 4'd12,
    PH_SKIP   = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_BAD_START = 3'd1,
    ST_NO_FF     = 3'd2,
    ST_SHORT_LEN = 3'd3,
    ST_ENDED     = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] height;
    logic [15:0] width;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/jfs_parser.sv]
`default_nettype none
module jfs_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       byte_value,
  input  wire logic             last_byte,
  output logic                  pipe_busy,
  output logic                  res_valid,
  output jfs_pkg::result_t      res
);
  import jfs_pkg::*;

  logic        pipe_valid;
  logic [7:0]  pipe_byte;
  logic        pipe_last;

  phase_t      phase, phase_next;
  logic [15:0] skip_left, skip_left_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] height_acc, height_acc_next;
  logic [15:0] width_acc, width_acc_next;
  logic        reported, reported_next;

  logic        emit;
  status_t     st;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign pipe_busy = pipe_valid;
  assign seg_len   = {length_high, pipe_byte};
  assign skip_dec  = (skip_left != 16'd0) ? (skip_left - 16'd1) : skip_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= take;
    end
    if (take) begin
      pipe_byte <= byte_value;
      pipe_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SOI_A;
      skip_left   <= 16'd0;
      length_high <= 8'd0;
      height_acc  <= 16'd0;
      width_acc   <= 16'd0;
      reported    <= 1'b0;
    end else begin
      phase       <= phase_next;
      skip_left   <= skip_left_next;
      length_high <= length_high_next;
      height_acc  <= height_acc_next;
      width_acc   <= width_acc_next;
      reported    <= reported_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    skip_left_next   = skip_left;
    length_high_next = length_high;
    height_acc_next  = height_acc;
    width_acc_next   = width_acc;
    reported_next    = reported;
    emit             = 1'b0;
    st               = ST_ENDED;
    if (pipe_valid && !reported) begin
      case (phase)
        PH_SOI_A: begin
          if (pipe_byte != MarkPrefix) begin
            emit = 1'b1;
            st   = ST_BAD_START;
          end else begin
            phase_next = PH_SOI_B;
          end
        end
        PH_SOI_B: begin
          if (pipe_byte != MarkSoi) begin
            emit = 1'b1;
            st   = ST_BAD_START;
          end else begin
            phase_next = PH_MARK_A;
          end
        end
        PH_MARK_A: begin
          if (pipe_byte != MarkPrefix) begin
            emit = 1'b1;
            st   = ST_NO_FF;
          end else begin
            phase_next = PH_MARK_B;
          end
        end
        PH_MARK_B: begin
          // stay on fill bytes
          if (pipe_byte != MarkPrefix) begin
            phase_next = (pipe_byte == MarkSof0 || pipe_byte == MarkSof2) ?
                         PH_SOF_L1 : PH_SEG_HI;
          end
        end
        PH_SOF_L1: phase_next = PH_SOF_L2;
        PH_SOF_L2: phase_next = PH_SOF_P;
        PH_SOF_P:  phase_next = PH_H_HI;
        PH_H_HI: begin
          height_acc_next = {pipe_byte, 8'd0};
          phase_next      = PH_H_LO;
        end
        PH_H_LO: begin
          height_acc_next = {height_acc[15:8], pipe_byte};
          phase_next      = PH_W_HI;
        end
        PH_W_HI: begin
          width_acc_next = {pipe_byte, 8'd0};
          phase_next     = PH_W_LO;
        end
        PH_W_LO: begin
          width_acc_next = {width_acc[15:8], pipe_byte};
          emit           = 1'b1;
          st             = ST_FOUND;
        end
        PH_SEG_HI: begin
          length_high_next = pipe_byte;
          phase_next       = PH_SEG_LO;
        end
        PH_SEG_LO: begin
          if (seg_len < 16'd2) begin
            emit = 1'b1;
            st   = ST_SHORT_LEN;
          end else begin
            skip_left_next = seg_len - 16'd2;
            phase_next     = (seg_len == 16'd2) ? PH_MARK_A : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_next = PH_MARK_A;
          end
        end
        default: phase_next = PH_SOI_A;
      endcase
      // a lone FF that ends the file is still a bad start
      if (phase == PH_SOI_A && pipe_last && pipe_byte == MarkPrefix) begin
        emit = 1'b1;
        st   = ST_BAD_START;
      end
      if (!emit && pipe_last) begin
        emit = 1'b1;
        st   = ST_ENDED;
      end
      if (emit) begin
        reported_next = 1'b1;
      end
    end
    // rearm after the last byte of a file
    if (pipe_valid && pipe_last) begin
      phase_next       = PH_SOI_A;
      skip_left_next   = 16'd0;
      length_high_next = 8'd0;
      height_acc_next  = 16'd0;
      width_acc_next   = 16'd0;
      reported_next    = 1'b0;
    end
  end

  always_comb begin
    res_valid  = emit;
    res.status = st;
    res.height = (st == ST_FOUND) ? height_acc : 16'd0;
    res.width  = (st == ST_FOUND) ? {width_acc[15:8], pipe_byte} : 16'd0;
  end

  a_one_result_per_file: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !reported)
    else $error("result emitted twice for one file");

  a_rearm_on_last: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid && pipe_last) |=> (phase == PH_SOI_A && !reported))
    else $error("parser not rearmed after last byte");

  a_found_at_width: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_FOUND) |-> phase == PH_W_LO)
    else $error("found reported outside width low byte");

endmodule
`default_nettype wire

[hw/rtl/jfs_out_queue.sv]
`default_nettype none
module jfs_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire jfs_pkg::result_t push_data,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [1:0]            level,
  output jfs_pkg::result_t      head
);
  import jfs_pkg::*;

  localparam logic [1:0] LastSlot = 2'(QueueDepth - 1);
  localparam logic [1:0] Full     = 2'(QueueDepth);

  result_t    slots [QueueDepth];
  logic [1:0] wr_ptr, rd_ptr, count;
  logic       do_pop;

  assign do_pop    = pop && (count != 2'd0);
  assign not_empty = (count != 2'd0);
  assign level     = count;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? 2'd0 : rd_ptr + 2'd1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != Full)
    else $error("result queue overflow");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("result queue level out of range");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (not_empty && !pop) |=> $stable(rd_ptr))
    else $error("head moved while stalled");

endmodule
`default_nettype wire

[hw/rtl/jpeg_frame_size_scanner.sv]
// JPEG frame size scanner.
// Input channel: one file byte per transaction on byte_value, with last_byte
// high on the final byte of a file; taken when in_valid is high and in_stall
// low. Output channel: at most one result per file (status, frame_height,
// frame_width), taken when out_valid is high and out_stall low.
// Status: found, bad start marker, missing FF, segment length below two, or
// stream ended. Height and width are zero unless the status is found.
// Throughput: one byte per cycle sustained while in_stall is low. A result
// reaches the output ports after the byte that causes it is accepted, via the
// input register, then the parse logic writing a three-entry result queue.
// When the receiver stalls, results wait in the queue and bytes keep flowing
// until the queue plus the byte in flight could fill it; in_stall then rises.
// Bytes after a file's result are dropped silently until its last byte,
// which rearms the parser for the next file.
// Reset (rst, synchronous) empties the queue and returns the parser to
// waiting for the start marker of a new file.
`default_nettype none
module jpeg_frame_size_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      frame_height,
  output logic [15:0]      frame_width
);
  import jfs_pkg::*;

  localparam logic [1:0] Full = 2'(QueueDepth);

  logic       take;
  logic       pipe_busy;
  logic       res_valid;
  result_t    res;
  result_t    head;
  logic [1:0] level;

  // reserve a queue slot for the byte in flight
  assign in_stall = (level == Full) || (level == Full - 2'd1 && pipe_busy);
  assign take     = in_valid && !in_stall;

  jfs_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .pipe_busy  (pipe_busy),
    .res_valid  (res_valid),
    .res        (res)
  );

  jfs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (!out_stall),
    .not_empty (out_valid),
    .level     (level),
    .head      (head)
  );

  assign status       = head.status;
  assign frame_height = head.height;
  assign frame_width  = head.width;

endmodule
`default_nettype wire
